// ===== sv/murmur_byte_hash_top_defines.svh =====
// Assertion shorthands shared by the verification code of the byte hash.
// All of them sample on clk and are switched off while rst_n is low.
`ifndef MURMUR_BYTE_HASH_TOP_DEFINES_SVH
`define MURMUR_BYTE_HASH_TOP_DEFINES_SVH

// Same-cycle implication.
`define MBH_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define MBH_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/mbh_pkg.sv =====
package mbh_pkg;

    // Multiplier constant. The low half is also the 32-bit Murmur2 constant.
    localparam logic [31:0] MUL_LO = 32'h5bd1e995;
    localparam logic [31:0] MUL_HI = 32'hc6a4a793;

    localparam logic [63:0] SEED_RESET      = 64'h0000_0000_c70f_6907;
    localparam logic        WORD_MODE_RESET = 1'b0;

    // Configuration register indexes.
    localparam int          CFG_IDX_W     = 1;
    localparam logic [0:0]  CFG_SEED      = 1'b0;
    localparam logic [0:0]  CFG_WORD_MODE = 1'b1;

    localparam int MBH_QUEUE_DEPTH = 2;

    // Item classes decided by the front end.
    localparam logic [1:0] CLS_EMPTY = 2'd0;
    localparam logic [1:0] CLS_TAIL  = 2'd1;
    localparam logic [1:0] CLS_FULL  = 2'd2;

    typedef struct packed {
        logic        mode32;
        logic        first;
        logic        last;
        logic [1:0]  cls;
        logic [63:0] data;
        logic [31:0] len;
    } item_t;

endpackage

// ===== sv/murmur_byte_hash_top.sv =====
// Channel   | Direction | Handshake           | Payload
// ----------+-----------+---------------------+-----------------------------------------
// input     | in        | in_valid / in_stall | data_word, byte_count, last_item,
//           |           |                     | message_length
// result    | out       | out_valid/out_stall | hash_value
// config    | in        | cfg_wr_en           | cfg_index, cfg_data
//
// An item's time in the back end is set by the single shared multiplier, which forms
// one product at a time: a full word needs three products, a short word one, an empty
// item none, the first item of a 64-bit message one more, and the last item one more.
// rst_n clears the control state asynchronously; seed returns to 0xc70f6907, mode to 64-bit.
// in_stall rises only when the item queue is full; out_stall holds the result register,
// and the back end keeps working until it needs that register again.
module murmur_byte_hash_top #(
    parameter int QUEUE_DEPTH = mbh_pkg::MBH_QUEUE_DEPTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [63:0]                  data_word,
    input  logic [3:0]                   byte_count,
    input  logic                         last_item,
    input  logic [31:0]                  message_length,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [63:0]                  hash_value,
    input  logic                         cfg_wr_en,
    input  logic [mbh_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                  cfg_data
);
    import mbh_pkg::*;

    // Configuration registers. The user must make writes only while the block is idle;
    // the block does not check this. The back end reads the seed as it opens a message.
    logic [63:0] seed_reg;
    logic [63:0] seed_next;
    logic        word_mode_reg;
    logic        word_mode_next;

    always_comb
    begin
        seed_next      = seed_reg;
        word_mode_next = word_mode_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_SEED:      seed_next      = cfg_data;
                CFG_WORD_MODE: word_mode_next = cfg_data[0];
                default:       seed_next      = seed_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg      <= SEED_RESET;
            word_mode_reg <= WORD_MODE_RESET;
        end
        else
        begin
            seed_reg      <= seed_next;
            word_mode_reg <= word_mode_next;
        end
    end

    // The front end classifies each transfer (first of a message, full word,
    // short tail or empty) and masks off the unused bytes.
    item_t       push_item;
    item_t       pop_item;
    logic        q_push;
    logic        q_pop;
    logic        q_full;
    logic        q_nonempty;
    logic [63:0] mul_op;
    logic        mul_mode32;
    logic [63:0] mul_product;

    mbh_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .data_word      (data_word),
        .byte_count     (byte_count),
        .last_item      (last_item),
        .message_length (message_length),
        .word_mode      (word_mode_reg),
        .q_full         (q_full),
        .in_stall       (in_stall),
        .q_push         (q_push),
        .q_item         (push_item)
    );

    // The queue lets the input side keep taking transfers while the back end
    // grinds through the multiplies of an earlier word.
    mbh_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .wr_item  (push_item),
        .pop      (q_pop),
        .rd_item  (pop_item),
        .full     (q_full),
        .nonempty (q_nonempty)
    );

    // The back end sequences the hash rounds through one shared multiplier
    // and owns the accumulator and the result register.
    mbh_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_nonempty),
        .q_item      (pop_item),
        .q_pop       (q_pop),
        .seed        (seed_reg),
        .mul_op      (mul_op),
        .mul_mode32  (mul_mode32),
        .mul_product (mul_product),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .hash_value  (hash_value)
    );

    mbh_mul u_mul (
        .clk     (clk),
        .op      (mul_op),
        .mode32  (mul_mode32),
        .product (mul_product)
    );

endmodule

// ===== sv/mbh_fifo.sv =====
module mbh_fifo #(
    parameter int DEPTH = mbh_pkg::MBH_QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  mbh_pkg::item_t wr_item,
    input  logic          pop,
    output mbh_pkg::item_t rd_item,
    output logic          full,
    output logic          nonempty
);
    import mbh_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t            slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wr_item;
        end
    end

    assign rd_item  = slot_reg[rd_ptr_reg];
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign nonempty = (count_reg != '0);

endmodule

// ===== sv/mbh_mul.sv =====
module mbh_mul (
    input  logic        clk,
    input  logic [63:0] op,
    input  logic        mode32,
    output logic [63:0] product
);
    import mbh_pkg::*;

    // Product modulo 2^64 from three 32x32 partial products. The high-by-high
    // term falls entirely above bit 63. In 32-bit mode the high constant half
    // is zero and the operand's upper half is zero.
    logic [31:0] mul_hi;
    logic [63:0] pp_ll_next;
    logic [31:0] pp_lh_next;
    logic [31:0] pp_hl_next;
    logic [63:0] pp_ll_reg;
    logic [31:0] pp_lh_reg;
    logic [31:0] pp_hl_reg;

    assign mul_hi     = mode32 ? 32'd0 : MUL_HI;
    assign pp_ll_next = op[31:0] * MUL_LO;
    assign pp_lh_next = op[31:0] * mul_hi;
    assign pp_hl_next = op[63:32] * MUL_LO;

    always_ff @(posedge clk)
    begin
        pp_ll_reg <= pp_ll_next;
        pp_lh_reg <= pp_lh_next;
        pp_hl_reg <= pp_hl_next;
    end

    assign product = pp_ll_reg + {pp_lh_reg + pp_hl_reg, 32'd0};

endmodule

// ===== sv/mbh_front.sv =====
module mbh_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic [63:0]    data_word,
    input  logic [3:0]     byte_count,
    input  logic           last_item,
    input  logic [31:0]    message_length,
    input  logic           word_mode,
    input  logic           q_full,
    output logic           in_stall,
    output logic           q_push,
    output mbh_pkg::item_t q_item
);
    import mbh_pkg::*;

    logic       in_message_reg;
    logic       in_message_next;
    logic       is_full;
    logic [7:0] byte_en;

    // A full word is 8 bytes, or 4 bytes in 32-bit mode; larger counts saturate.
    assign is_full = word_mode ? (byte_count >= 4'd4) : (byte_count >= 4'd8);

    // Keep only the bytes that take part; bytes 4 to 7 never do in 32-bit mode.
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            byte_en[i] = (4'(i) < byte_count) && (!word_mode || i < 4);
        end
    end

    always_comb
    begin
        q_item.mode32 = word_mode;
        q_item.first  = !in_message_reg;
        q_item.last   = last_item;
        q_item.len    = message_length;
        for (int i = 0; i < 8; i++)
        begin
            q_item.data[8*i +: 8] = byte_en[i] ? data_word[8*i +: 8] : 8'd0;
        end
        if (byte_count == 4'd0)
        begin
            q_item.cls = CLS_EMPTY;
        end
        else if (is_full)
        begin
            q_item.cls = CLS_FULL;
        end
        else
        begin
            q_item.cls = CLS_TAIL;
        end
    end

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    always_comb
    begin
        in_message_next = in_message_reg;
        if (q_push)
        begin
            in_message_next = !last_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_message_reg <= 1'b0;
        end
        else
        begin
            in_message_reg <= in_message_next;
        end
    end

endmodule

// ===== sv/mbh_back.sv =====
module mbh_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  mbh_pkg::item_t q_item,
    output logic           q_pop,
    input  logic [63:0]    seed,
    output logic [63:0]    mul_op,
    output logic           mul_mode32,
    input  logic [63:0]    mul_product,
    input  logic           out_stall,
    output logic           out_valid,
    output logic [63:0]    hash_value
);
    import mbh_pkg::*;

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_SEED_PP  = 4'd1;
    localparam logic [3:0] ST_SEED_RES = 4'd2;
    localparam logic [3:0] ST_BODY     = 4'd3;
    localparam logic [3:0] ST_K1_PP    = 4'd4;
    localparam logic [3:0] ST_K1_RES   = 4'd5;
    localparam logic [3:0] ST_K2_PP    = 4'd6;
    localparam logic [3:0] ST_K2_RES   = 4'd7;
    localparam logic [3:0] ST_A_PP     = 4'd8;
    localparam logic [3:0] ST_A_RES    = 4'd9;
    localparam logic [3:0] ST_FIN      = 4'd10;
    localparam logic [3:0] ST_F_PP     = 4'd11;
    localparam logic [3:0] ST_F_RES    = 4'd12;

    logic [3:0]  state_reg;
    logic [3:0]  state_next;
    item_t       cur_reg;
    item_t       cur_next;
    logic [63:0] acc_reg;
    logic [63:0] acc_next;
    logic [63:0] op_reg;
    logic [63:0] op_next;
    logic [31:0] kx_reg;
    logic [31:0] kx_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [63:0] hash_reg;
    logic [63:0] hash_next;
    logic [31:0] p32;
    logic [31:0] a32;
    logic        out_free;

    assign p32      = mul_product[31:0];
    assign a32      = acc_reg[31:0];
    assign out_free = !out_valid_reg || !out_stall;
    assign q_pop    = (state_reg == ST_IDLE) && q_valid;

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        acc_next       = acc_reg;
        op_next        = op_reg;
        kx_next        = kx_reg;
        hash_next      = hash_reg;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    cur_next = q_item;
                    if (q_item.first && !q_item.mode32)
                    begin
                        op_next    = {32'd0, q_item.len};
                        state_next = ST_SEED_PP;
                    end
                    else
                    begin
                        if (q_item.first)
                        begin
                            acc_next = {32'd0, seed[31:0] ^ q_item.len};
                        end
                        state_next = ST_BODY;
                    end
                end
            end
            ST_SEED_PP:
            begin
                state_next = ST_SEED_RES;
            end
            ST_SEED_RES:
            begin
                acc_next   = seed ^ mul_product;
                state_next = ST_BODY;
            end
            ST_BODY:
            begin
                kx_next = 32'd0;
                unique case (cur_reg.cls)
                    CLS_FULL:
                    begin
                        op_next    = cur_reg.data;
                        state_next = ST_K1_PP;
                    end
                    CLS_TAIL:
                    begin
                        op_next    = cur_reg.mode32 ? {32'd0, a32 ^ cur_reg.data[31:0]}
                                                    : acc_reg ^ cur_reg.data;
                        state_next = ST_A_PP;
                    end
                    default:
                    begin
                        // The 32-bit form keeps only the low accumulator half,
                        // even when the item carries no bytes.
                        if (cur_reg.mode32)
                        begin
                            acc_next = {32'd0, a32};
                        end
                        state_next = ST_FIN;
                    end
                endcase
            end
            ST_K1_PP:
            begin
                state_next = ST_K1_RES;
            end
            ST_K1_RES:
            begin
                op_next    = cur_reg.mode32 ? {32'd0, p32 ^ (p32 >> 24)}
                                            : mul_product ^ (mul_product >> 47);
                state_next = ST_K2_PP;
            end
            ST_K2_PP:
            begin
                state_next = ST_K2_RES;
            end
            ST_K2_RES:
            begin
                // 32-bit mode multiplies the accumulator first and folds in
                // the mixed word afterwards; 64-bit mode folds it in first.
                if (cur_reg.mode32)
                begin
                    op_next = {32'd0, a32};
                    kx_next = p32;
                end
                else
                begin
                    op_next = acc_reg ^ mul_product;
                end
                state_next = ST_A_PP;
            end
            ST_A_PP:
            begin
                state_next = ST_A_RES;
            end
            ST_A_RES:
            begin
                acc_next   = cur_reg.mode32 ? {32'd0, p32 ^ kx_reg} : mul_product;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (cur_reg.last)
                begin
                    op_next    = cur_reg.mode32 ? {32'd0, a32 ^ (a32 >> 13)}
                                                : acc_reg ^ (acc_reg >> 47);
                    state_next = ST_F_PP;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_F_PP:
            begin
                state_next = ST_F_RES;
            end
            ST_F_RES:
            begin
                if (out_free)
                begin
                    hash_next      = cur_reg.mode32 ? {32'd0, p32 ^ (p32 >> 15)}
                                                    : mul_product ^ (mul_product >> 47);
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            acc_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            acc_reg       <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        op_reg   <= op_next;
        kx_reg   <= kx_next;
        hash_reg <= hash_next;
    end

    assign mul_op     = op_reg;
    assign mul_mode32 = cur_reg.mode32;
    assign out_valid  = out_valid_reg;
    assign hash_value = hash_reg;

endmodule

// ===== sv/mbh_checker.sv =====
`include "murmur_byte_hash_top_defines.svh"

module mbh_checker #(
    parameter int QUEUE_DEPTH = mbh_pkg::MBH_QUEUE_DEPTH
) (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        last_item,
    input logic        out_valid,
    input logic        out_stall,
    input logic [63:0] hash_value
);
    localparam int PEND_W = $clog2(QUEUE_DEPTH + 3);

    // Messages closed at the input whose hash has not yet been transferred out.
    logic [PEND_W-1:0] pending_reg;
    logic [PEND_W-1:0] pending_next;
    logic              last_in;
    logic              out_xfer;

    assign last_in  = in_valid && !in_stall && last_item;
    assign out_xfer = out_valid && !out_stall;

    always_comb
    begin
        pending_next = pending_reg + PEND_W'(last_in) - PEND_W'(out_xfer);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    `MBH_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid, "result lost while stalled")
    `MBH_ASSERT_NXT(a_out_stable, out_valid && out_stall, $stable(hash_value), "result changed while stalled")
    `MBH_ASSERT_IMP(a_out_has_msg, out_valid, pending_reg != '0, "result without a closed message")
    `MBH_ASSERT_IMP(a_in_capacity, pending_reg >= PEND_W'(QUEUE_DEPTH + 2), in_stall, "input taken beyond capacity")

endmodule

bind murmur_byte_hash_top mbh_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_mbh_checker (.*);
